[rtl/tbpc_pkg.sv]
// shared types, register indexes and reset values of the two-button press classifier
`default_nettype none

package tbpc_pkg;

    localparam int unsigned STAMP_W    = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [2:0] {
        EV_OK_SHORT = 3'd0,
        EV_OK_LONG  = 3'd1,
        EV_UP_SHORT = 3'd2,
        EV_UP_LONG  = 3'd3,
        EV_BOTH     = 3'd4
    } event_code_t;

    localparam logic [CFG_IDX_W-1:0] REG_SCAN_PERIOD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BOTH_HOLD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOTH_HOLDOFF = 3'd4;

    localparam logic [7:0]  RST_SCAN_PERIOD  = 8'd10;
    localparam logic [15:0] RST_DEBOUNCE     = 16'd20;
    localparam logic [15:0] RST_LONG_PRESS   = 16'd800;
    localparam logic [15:0] RST_BOTH_HOLD    = 16'd500;
    localparam logic [15:0] RST_BOTH_HOLDOFF = 16'd1000;

    typedef struct packed {
        logic [7:0]  scan_period_ms;
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] both_hold_ms;
        logic [15:0] both_holdoff_ms;
    } cfg_t;

    typedef struct packed {
        logic short_hit;
        logic long_hit;
        logic level_prev;
    } button_status_t;

endpackage

`default_nettype wire

[rtl/tbpc_cfg.sv]
// configuration register file
`default_nettype none

module tbpc_cfg (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [tbpc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [tbpc_pkg::CFG_DATA_W-1:0]   cfg_wr_data,
    output tbpc_pkg::cfg_t                         cfg
);

    tbpc_pkg::cfg_t cfg_reg;
    tbpc_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_wr_index)
                tbpc_pkg::REG_SCAN_PERIOD:  cfg_next.scan_period_ms  = cfg_wr_data[7:0];
                tbpc_pkg::REG_DEBOUNCE:     cfg_next.debounce_ms     = cfg_wr_data;
                tbpc_pkg::REG_LONG_PRESS:   cfg_next.long_press_ms   = cfg_wr_data;
                tbpc_pkg::REG_BOTH_HOLD:    cfg_next.both_hold_ms    = cfg_wr_data;
                tbpc_pkg::REG_BOTH_HOLDOFF: cfg_next.both_holdoff_ms = cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.scan_period_ms  <= tbpc_pkg::RST_SCAN_PERIOD;
            cfg_reg.debounce_ms     <= tbpc_pkg::RST_DEBOUNCE;
            cfg_reg.long_press_ms   <= tbpc_pkg::RST_LONG_PRESS;
            cfg_reg.both_hold_ms    <= tbpc_pkg::RST_BOTH_HOLD;
            cfg_reg.both_holdoff_ms <= tbpc_pkg::RST_BOTH_HOLDOFF;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

[rtl/tbpc_button.sv]
// press tracker for one button: debounce, long press and short press on release
`default_nettype none

module tbpc_button (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              scan,
    input  wire logic [tbpc_pkg::STAMP_W-1:0]      now_ms,
    input  wire logic                              level,
    input  wire logic [15:0]                       debounce_ms,
    input  wire logic [15:0]                       long_press_ms,
    output tbpc_pkg::button_status_t               status
);

    logic                             prev_reg;
    logic                             prev_next;
    logic                             confirmed_reg;
    logic                             confirmed_next;
    logic                             long_reg;
    logic                             long_next;
    logic [tbpc_pkg::STAMP_W-1:0]     start_reg;
    logic [tbpc_pkg::STAMP_W-1:0]     start_next;
    logic [tbpc_pkg::STAMP_W-1:0]     held;
    logic                             past_debounce;
    logic                             past_long;
    logic                             short_hit;
    logic                             long_hit;

    assign held          = now_ms - start_reg;
    assign past_debounce = held >= {16'd0, debounce_ms};
    assign past_long     = held >= {16'd0, long_press_ms};

    always_comb begin
        prev_next      = prev_reg;
        confirmed_next = confirmed_reg;
        long_next      = long_reg;
        start_next     = start_reg;
        short_hit      = 1'b0;
        long_hit       = 1'b0;
        if (scan) begin
            prev_next = level;
            if (level && !prev_reg) begin
                start_next     = now_ms;
                confirmed_next = 1'b0;
                long_next      = 1'b0;
            end else if (level && prev_reg) begin
                if (past_debounce) begin
                    confirmed_next = 1'b1;
                end
                if (!long_reg && past_long) begin
                    long_next = 1'b1;
                    long_hit  = 1'b1;
                end
            end else if (!level && prev_reg) begin
                short_hit      = confirmed_reg && !long_reg && !past_long;
                confirmed_next = 1'b0;
                long_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg      <= 1'b0;
            confirmed_reg <= 1'b0;
            long_reg      <= 1'b0;
            start_reg     <= '0;
        end else begin
            prev_reg      <= prev_next;
            confirmed_reg <= confirmed_next;
            long_reg      <= long_next;
            start_reg     <= start_next;
        end
    end

    assign status.short_hit  = short_hit;
    assign status.long_hit   = long_hit;
    assign status.level_prev = prev_reg;

    a_long_only_held: assert property (@(posedge aclk) disable iff (!aresetn)
        long_reg |-> prev_reg)
        else $error("long flag set while button released");

    a_confirmed_only_held: assert property (@(posedge aclk) disable iff (!aresetn)
        confirmed_reg |-> prev_reg)
        else $error("confirmed flag set while button released");

    a_one_event: assert property (@(posedge aclk) disable iff (!aresetn)
        !(short_hit && long_hit))
        else $error("short and long press in the same scan");

endmodule

`default_nettype wire

[rtl/two_button_press_classifier_unit.sv]
// top level of the two-button press classifier
// an accepted sample is held in the input register, and its result is registered in the result register
// throughput: one sample per cycle; the input register and the result register
// each advance whenever the result register is empty or being taken
// samples inside the scan period and scans with no event give no result
// reset (synchronous, aresetn low) restores register reset values and clears valid and tracking state
`default_nettype none

module two_button_press_classifier_unit (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output      logic                              s_tready,
    input  wire logic [39:0]                       s_tdata,  // now_ms, ok_down, up_down
    output      logic                              m_tvalid,
    input  wire logic                              m_tready,
    output      logic [7:0]                        m_tdata,  // event_code
    input  wire logic                              cfg_wr_en,
    input  wire logic [tbpc_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  wire logic [tbpc_pkg::CFG_DATA_W-1:0]   cfg_wr_data
);

    tbpc_pkg::cfg_t                   cfg;
    tbpc_pkg::button_status_t         ok_status;
    tbpc_pkg::button_status_t         up_status;

    logic                             in_valid_reg;
    logic [tbpc_pkg::STAMP_W-1:0]     in_now_reg;
    logic                             in_ok_reg;
    logic                             in_up_reg;
    logic                             out_valid_reg;
    logic                             out_valid_next;
    tbpc_pkg::event_code_t            out_code_reg;
    tbpc_pkg::event_code_t            out_code_next;
    logic [tbpc_pkg::STAMP_W-1:0]     last_scan_reg;
    logic [tbpc_pkg::STAMP_W-1:0]     both_start_reg;
    logic [tbpc_pkg::STAMP_W-1:0]     both_start_next;
    logic [tbpc_pkg::STAMP_W-1:0]     both_base;
    logic [tbpc_pkg::STAMP_W-1:0]     both_elapsed;
    logic [tbpc_pkg::STAMP_W-1:0]     since_scan;
    logic                             out_free;
    logic                             step;
    logic                             scan_ok;
    logic                             scan;
    logic                             both_held;
    logic                             both_prev;
    logic                             both_hit;
    logic                             any_event;

    tbpc_cfg u_cfg (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg)
    );

    assign out_free = !out_valid_reg || m_tready;
    assign step     = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_now_reg <= s_tdata[31:0];
            in_ok_reg  <= s_tdata[32];
            in_up_reg  <= s_tdata[33];
        end
    end

    assign since_scan = in_now_reg - last_scan_reg;
    assign scan_ok    = since_scan >= {24'd0, cfg.scan_period_ms};
    assign scan       = step && scan_ok;

    tbpc_button u_ok (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .scan          (scan),
        .now_ms        (in_now_reg),
        .level         (in_ok_reg),
        .debounce_ms   (cfg.debounce_ms),
        .long_press_ms (cfg.long_press_ms),
        .status        (ok_status)
    );

    tbpc_button u_up (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .scan          (scan),
        .now_ms        (in_now_reg),
        .level         (in_up_reg),
        .debounce_ms   (cfg.debounce_ms),
        .long_press_ms (cfg.long_press_ms),
        .status        (up_status)
    );

    // both timer restarts when both buttons become held together, and is moved past the hold-off after a both event
    assign both_held    = in_ok_reg && in_up_reg;
    assign both_prev    = ok_status.level_prev && up_status.level_prev;
    assign both_base    = both_prev ? both_start_reg : in_now_reg;
    assign both_elapsed = in_now_reg - both_base;
    assign both_hit     = scan && both_held && !both_elapsed[tbpc_pkg::STAMP_W-1]
                          && (both_elapsed >= {16'd0, cfg.both_hold_ms});

    always_comb begin
        both_start_next = both_start_reg;
        if (scan && both_held) begin
            if (both_hit) begin
                both_start_next = in_now_reg + {16'd0, cfg.both_holdoff_ms};
            end else begin
                both_start_next = both_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_scan_reg  <= '0;
            both_start_reg <= '0;
        end else begin
            if (scan) begin
                last_scan_reg <= in_now_reg;
            end
            both_start_reg <= both_start_next;
        end
    end

    // when several events fall in one scan, priority is up, then ok, then both; long before short
    assign any_event = both_hit || ok_status.short_hit || ok_status.long_hit
                       || up_status.short_hit || up_status.long_hit;

    always_comb begin
        if (up_status.long_hit) begin
            out_code_next = tbpc_pkg::EV_UP_LONG;
        end else if (up_status.short_hit) begin
            out_code_next = tbpc_pkg::EV_UP_SHORT;
        end else if (ok_status.long_hit) begin
            out_code_next = tbpc_pkg::EV_OK_LONG;
        end else if (ok_status.short_hit) begin
            out_code_next = tbpc_pkg::EV_OK_SHORT;
        end else begin
            out_code_next = tbpc_pkg::EV_BOTH;
        end
    end

    assign out_valid_next = out_free ? (scan && any_event) : out_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            out_code_reg <= out_code_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_code_reg};

    a_code_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[2:0] == tbpc_pkg::EV_OK_SHORT
                      || m_tdata[2:0] == tbpc_pkg::EV_OK_LONG
                      || m_tdata[2:0] == tbpc_pkg::EV_UP_SHORT
                      || m_tdata[2:0] == tbpc_pkg::EV_UP_LONG
                      || m_tdata[2:0] == tbpc_pkg::EV_BOTH))
        else $error("event code out of range");

    a_skipped_sample_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (step && !scan_ok) |=> !m_tvalid)
        else $error("result from a sample inside the scan period");

    a_scan_stamp: assert property (@(posedge aclk) disable iff (!aresetn)
        scan |=> (last_scan_reg == $past(in_now_reg)))
        else $error("scan stamp not taken from the accepted scan");

    a_both_needs_held: assert property (@(posedge aclk) disable iff (!aresetn)
        both_hit |=> (ok_status.level_prev && up_status.level_prev))
        else $error("both event without both buttons held");

endmodule

`default_nettype wire

[tb/testbench.sv]
// testbench for the two-button press classifier: directed presses, register extremes, random press sequences
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SETTLE_CYCLES  = 6;
    localparam int unsigned TIMEOUT_CYCLES = 400000;
    localparam int unsigned RANDOM_SCANS   = 900;

    // indexes beyond the register file, writes there must be ignored
    localparam logic [tbpc_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd5;
    localparam logic [tbpc_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    logic                            aclk         = 1'b0;
    logic                            aresetn      = 1'b0;
    logic                            s_tvalid     = 1'b0;
    logic                            s_tready;
    logic [39:0]                     s_tdata      = '0;  // now_ms, ok_down, up_down
    logic                            m_tvalid;
    logic                            m_tready     = 1'b0;
    logic [7:0]                      m_tdata;            // event_code
    logic                            cfg_wr_en    = 1'b0;
    logic [tbpc_pkg::CFG_IDX_W-1:0]  cfg_wr_index = '0;
    logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_wr_data  = '0;

    // register copies
    logic [7:0]  scan_period  = tbpc_pkg::RST_SCAN_PERIOD;
    logic [15:0] confirm_time = tbpc_pkg::RST_DEBOUNCE;
    logic [15:0] long_time    = tbpc_pkg::RST_LONG_PRESS;
    logic [15:0] both_time    = tbpc_pkg::RST_BOTH_HOLD;
    logic [15:0] holdoff_time = tbpc_pkg::RST_BOTH_HOLDOFF;

    // button tracking state
    logic [31:0] last_scan      = '0;
    logic [1:0]  level_seen     = '0;
    logic [1:0]  confirmed      = '0;
    logic [1:0]  long_seen      = '0;
    logic [31:0] press_start [2] = '{32'd0, 32'd0};
    logic [31:0] both_start     = '0;

    tbpc_pkg::event_code_t expected_events [$];
    tbpc_pkg::event_code_t head_event;

    logic [31:0] clock_ms = '0;
    bit          bursty = 1'b1;
    int unsigned scans = 0;
    int unsigned results_checked = 0;
    int unsigned settings_used = 1;
    int unsigned cycle_count = 0;
    int          errors = 0;

    two_button_press_classifier_unit uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data)
    );

    always #10 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    task automatic classify_sample(input logic [31:0] now, input logic ok, input logic up);
        logic [31:0] elapsed;
        logic [31:0] held;
        logic [1:0]  level;
        logic        fired;
        tbpc_pkg::event_code_t ev;
        begin
            if (now - last_scan < {24'd0, scan_period}) return;
            scans++;
            last_scan = now;
            level = {up, ok};
            fired = 1'b0;
            ev = tbpc_pkg::EV_OK_SHORT;
            if (ok && up) begin
                if (!(level_seen[0] && level_seen[1])) both_start = now;
                elapsed = now - both_start;
                if (!elapsed[31] && elapsed >= {16'd0, both_time}) begin
                    ev = tbpc_pkg::EV_BOTH;
                    fired = 1'b1;
                    both_start = now + {16'd0, holdoff_time};
                end
            end
            for (int b = 0; b < 2; b++) begin
                held = now - press_start[b];
                if (level[b] && !level_seen[b]) begin
                    press_start[b] = now;
                    confirmed[b] = 1'b0;
                    long_seen[b] = 1'b0;
                end else if (level[b] && level_seen[b]) begin
                    if (!confirmed[b] && held >= {16'd0, confirm_time}) confirmed[b] = 1'b1;
                    if (!long_seen[b] && held >= {16'd0, long_time}) begin
                        long_seen[b] = 1'b1;
                        ev = (b == 0) ? tbpc_pkg::EV_OK_LONG : tbpc_pkg::EV_UP_LONG;
                        fired = 1'b1;
                    end
                end else if (!level[b] && level_seen[b]) begin
                    if (confirmed[b] && !long_seen[b] && held < {16'd0, long_time}) begin
                        ev = (b == 0) ? tbpc_pkg::EV_OK_SHORT : tbpc_pkg::EV_UP_SHORT;
                        fired = 1'b1;
                    end
                    confirmed[b] = 1'b0;
                    long_seen[b] = 1'b0;
                end
                level_seen[b] = level[b];
            end
            if (fired) expected_events.push_back(ev);
        end
    endtask

    task automatic send_sample(input logic [31:0] now, input logic ok, input logic up);
        int unsigned gap;
        begin
            gap = bursty ? $urandom_range(0, 12) : 0;
            if (gap != 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tdata <= {6'd0, up, ok, now};
            do @(posedge aclk); while (!s_tready);
            classify_sample(now, ok, up);
        end
    endtask

    task automatic advance(input int unsigned delta, input logic [1:0] level);
        clock_ms = clock_ms + delta;
        send_sample(clock_ms, level[0], level[1]);
    endtask

    task automatic drain_pipeline();
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [tbpc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tbpc_pkg::CFG_DATA_W-1:0] data);
        cfg_wr_en <= 1'b1;
        cfg_wr_index <= idx;
        cfg_wr_data <= data;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            tbpc_pkg::REG_SCAN_PERIOD:  scan_period = data[7:0];
            tbpc_pkg::REG_DEBOUNCE:     confirm_time = data;
            tbpc_pkg::REG_LONG_PRESS:   long_time = data;
            tbpc_pkg::REG_BOTH_HOLD:    both_time = data;
            tbpc_pkg::REG_BOTH_HOLDOFF: holdoff_time = data;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_config(input logic [15:0] scan, input logic [15:0] deb,
                              input logic [15:0] lng, input logic [15:0] both,
                              input logic [15:0] hoff);
        write_reg(tbpc_pkg::REG_SCAN_PERIOD, scan);
        write_reg(tbpc_pkg::REG_DEBOUNCE, deb);
        write_reg(tbpc_pkg::REG_LONG_PRESS, lng);
        write_reg(tbpc_pkg::REG_BOTH_HOLD, both);
        write_reg(tbpc_pkg::REG_BOTH_HOLDOFF, hoff);
        settings_used++;
    endtask

    // mostly a spacing past the scan period, sometimes one that falls inside it
    function automatic int unsigned next_step(input int unsigned unit);
        if ($urandom_range(0, 7) == 0) return $urandom_range(0, scan_period);
        return scan_period + $urandom_range(0, unit);
    endfunction

    task automatic press_sequence(input logic [1:0] mask);
        int unsigned unit;
        int unsigned hold;
        int unsigned held;
        int unsigned step;
        logic [1:0]  lead;
        begin
            unit = long_time / 8 + scan_period + 1;
            hold = $urandom_range(0, long_time + both_time + holdoff_time + unit);
            lead = $urandom_range(0, 1) ? 2'b01 : 2'b10;
            held = 0;
            if (mask == 2'b11 && $urandom_range(0, 1)) advance(next_step(unit), lead);
            advance(next_step(unit), mask);
            while (held < hold) begin
                step = next_step(unit);
                held += step;
                advance(step, mask);
            end
            if (mask == 2'b11 && $urandom_range(0, 1)) advance(next_step(unit), lead);
            advance(next_step(unit), 2'b00);
        end
    endtask

    task automatic random_presses(input int unsigned count);
        int unsigned target;
        int unsigned pick;
        begin
            target = scans + count;
            while (scans < target) begin
                pick = $urandom_range(0, 15);
                if (pick < 4) press_sequence(2'b01);
                else if (pick < 8) press_sequence(2'b10);
                else if (pick < 12) press_sequence(2'b11);
                else if (pick < 15) begin
                    repeat ($urandom_range(1, 6))
                        advance($urandom_range(0, 2 * scan_period + 2), 2'($urandom_range(0, 3)));
                end else begin
                    advance($urandom(), 2'($urandom_range(0, 3)));
                end
            end
        end
    endtask

    task automatic test_directed_presses();
        send_sample(32'd0, 1'b0, 1'b0);
        send_sample(32'd5, 1'b1, 1'b0);
        send_sample(32'd10, 1'b1, 1'b0);
        send_sample(32'd40, 1'b1, 1'b0);
        send_sample(32'd60, 1'b0, 1'b0);
        send_sample(32'd70, 1'b1, 1'b0);
        send_sample(32'd80, 1'b0, 1'b0);
        send_sample(32'd90, 1'b0, 1'b1);
        send_sample(32'd990, 1'b0, 1'b1);
        send_sample(32'd1000, 1'b0, 1'b0);
        send_sample(32'd1010, 1'b1, 1'b1);
        send_sample(32'd1610, 1'b1, 1'b1);
        send_sample(32'd1910, 1'b1, 1'b1);
        send_sample(32'd3210, 1'b1, 1'b1);
        send_sample(32'd3220, 1'b0, 1'b1);
        send_sample(32'd3230, 1'b0, 1'b0);
        // timestamps wrapping through zero
        send_sample(32'hFFFF_FFF0, 1'b0, 1'b1);
        send_sample(32'hFFFF_FFFF, 1'b0, 1'b1);
        send_sample(32'h0000_0009, 1'b0, 1'b1);
        send_sample(32'h0000_0013, 1'b0, 1'b0);
        send_sample(32'd29, 1'b1, 1'b0);
        send_sample(32'd829, 1'b1, 1'b0);
        send_sample(32'd839, 1'b0, 1'b0);
        // release scan lands past the long time without a long event
        send_sample(32'd849, 1'b1, 1'b0);
        send_sample(32'd869, 1'b1, 1'b0);
        send_sample(32'd2000, 1'b0, 1'b0);
        clock_ms = 32'd2000;
        drain_pipeline();
    endtask

    task automatic test_register_extremes();
        // scan period data above bit 7 is dropped, leaving zero
        set_config(16'hAB00, 16'd0, 16'd0, 16'd0, 16'd0);
        write_reg(REG_UNUSED_LO, 16'hFFFF);
        write_reg(REG_UNUSED_HI, 16'h0001);
        random_presses(60);
        drain_pipeline();
        set_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_presses(60);
        drain_pipeline();
        set_config(16'd1, 16'd0, 16'd1, 16'd1, 16'd0);
        random_presses(60);
        drain_pipeline();
    endtask

    task automatic test_random_sequences();
        int unsigned target;
        begin
            target = scans + RANDOM_SCANS;
            while (scans < target) begin
                set_config($urandom_range(1, 20), $urandom_range(0, 60), $urandom_range(1, 300),
                           $urandom_range(1, 200), $urandom_range(0, 300));
                bursty = $urandom_range(0, 2) != 0;
                random_presses($urandom_range(80, 200));
                drain_pipeline();
            end
            bursty = 1'b1;
        end
    endtask

    // result side: random stall before each transaction while bursty
    initial begin : result_sink
        int unsigned stall;
        @(posedge aclk);
        forever begin
            stall = bursty ? $urandom_range(0, 12) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                $error("event_code: expected none, got %0d", m_tdata);
                errors++;
            end else begin
                head_event = expected_events.pop_front();
                results_checked++;
                if (m_tdata !== {5'd0, head_event}) begin
                    $error("event_code: expected %0d, got %0d", head_event, m_tdata);
                    errors++;
                end
            end
        end
    end

    initial begin
        wait (cycle_count == TIMEOUT_CYCLES);
        $display("timeout after %0d cycles", cycle_count);
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        test_directed_presses();
        test_register_extremes();
        test_random_sequences();
        $display("covered %0d accepted scans across %0d register settings", scans, settings_used);
        $display("checked %0d button events in %0d cycles", results_checked, cycle_count);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
